// ===== design/mvts_pkg.sv =====
package mvts_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int INDEX_BITS = 16;
  localparam int ONE        = 1 << FRAC_BITS;

  // register indexes on the configuration port
  localparam logic [2:0] REG_FACTOR = 3'd0;
  localparam logic [2:0] REG_AXIS   = 3'd1;
  localparam logic [2:0] REG_COLOR  = 3'd2;
  localparam logic [2:0] REG_ROW0   = 3'd3;
  localparam logic [2:0] REG_ROW1   = 3'd4;
  localparam logic [2:0] REG_ROW2   = 3'd5;
  localparam logic [2:0] REG_ROW3   = 3'd6;

  typedef struct packed {
    logic [12:0] factor;
    logic [47:0] axis;
    logic [47:0] color;
    logic [63:0] row0;
    logic [63:0] row1;
    logic [63:0] row2;
    logic [63:0] row3;
  } cfg_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/morph_vertex_transform_shade.sv =====
// channel | ports                              | transfer when
// --------+------------------------------------+------------------------
// input   | in_start, in_busy, in_* fields     | in_start && !in_busy
// result  | out_strobe, out_* fields           | out_strobe (one cycle)
// config  | cfg_psel/penable/pwrite/paddr/...  | psel&penable&pwrite
// five-stage pipeline: one vertex per clock
// the stages are blend (2), matrix/normal products, sums, color scale
// in_busy is always low since the receiver cannot stall
// rst_n clears valid bits and config registers; pipeline contents are dropped
module morph_vertex_transform_shade
  import mvts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_start,
  output logic               in_busy,
  input  logic signed [15:0] in_cur_x,
  input  logic signed [15:0] in_cur_y,
  input  logic signed [15:0] in_cur_z,
  input  logic signed [15:0] in_next_x,
  input  logic signed [15:0] in_next_y,
  input  logic signed [15:0] in_next_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [15:0]        in_cur_index,
  input  logic [15:0]        in_next_index,
  output logic               out_strobe,
  output logic signed [31:0] out_clip_x,
  output logic signed [31:0] out_clip_y,
  output logic signed [31:0] out_clip_z,
  output logic signed [31:0] out_clip_w,
  output logic [12:0]        out_red,
  output logic [12:0]        out_green,
  output logic [12:0]        out_blue,
  output logic               out_pair_mismatch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [5:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t               cfg;
  logic signed [15:0] cur [3];
  logic signed [15:0] nxt [3];
  logic signed [15:0] nrm [3];
  logic               bv;
  logic signed [16:0] pos [3];
  logic signed [15:0] bnrm [3];
  logic               bmis;
  logic signed [31:0] clip [4];
  logic [12:0]        col [3];

  assign in_busy    = 1'b0;
  assign cfg_pready = 1'b1;

  assign cur = '{in_cur_x, in_cur_y, in_cur_z};
  assign nxt = '{in_next_x, in_next_y, in_next_z};
  assign nrm = '{in_normal_x, in_normal_y, in_normal_z};

  mvts_regs u_regs (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .cfg(cfg)
  );

  mvts_blend u_blend (
    .clk, .rst_n, .in_vld(in_start & ~in_busy),
    .cur, .nxt, .nrm, .cur_index(in_cur_index), .next_index(in_next_index),
    .factor(cfg.factor), .out_vld(bv), .pos, .nrm_o(bnrm), .mis(bmis)
  );

  mvts_xform u_xform (
    .clk, .rst_n, .in_vld(bv), .pos, .nrm(bnrm), .mis(bmis), .cfg,
    .out_vld(out_strobe), .clip, .col, .out_mis(out_pair_mismatch)
  );

  assign out_clip_x = clip[0];
  assign out_clip_y = clip[1];
  assign out_clip_z = clip[2];
  assign out_clip_w = clip[3];
  assign out_red    = col[0];
  assign out_green  = col[1];
  assign out_blue   = col[2];

endmodule

// ===== design/mvts_regs.sv =====
module mvts_regs
  import mvts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[5:3];
  assign wr  = psel & penable & pwrite;
  assign cfg = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_FACTOR: cfg_r.factor <= pwdata[12:0];
        REG_AXIS:   cfg_r.axis   <= pwdata[47:0];
        REG_COLOR:  cfg_r.color  <= pwdata[47:0];
        REG_ROW0:   cfg_r.row0   <= pwdata;
        REG_ROW1:   cfg_r.row1   <= pwdata;
        REG_ROW2:   cfg_r.row2   <= pwdata;
        REG_ROW3:   cfg_r.row3   <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_FACTOR: prdata = {51'd0, cfg_r.factor};
      REG_AXIS:   prdata = {16'd0, cfg_r.axis};
      REG_COLOR:  prdata = {16'd0, cfg_r.color};
      REG_ROW0:   prdata = cfg_r.row0;
      REG_ROW1:   prdata = cfg_r.row1;
      REG_ROW2:   prdata = cfg_r.row2;
      REG_ROW3:   prdata = cfg_r.row3;
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== design/mvts_blend.sv =====
module mvts_blend
  import mvts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] cur [3],
  input  logic signed [15:0] nxt [3],
  input  logic signed [15:0] nrm [3],
  input  logic [15:0]        cur_index,
  input  logic [15:0]        next_index,
  input  logic [12:0]        factor,
  output logic               out_vld,
  output logic signed [16:0] pos [3],
  output logic signed [15:0] nrm_o [3],
  output logic               mis
);

  // stage 1: compare, clamp the factor and difference
  logic               v1_r;
  logic               mis1_r;
  logic signed [15:0] cur1_r [3];
  logic signed [16:0] dif1_r [3];
  logic signed [15:0] nrm1_r [3];
  logic [12:0]        t1_r;
  logic               mis_nxt;

  assign mis_nxt = cur_index[INDEX_BITS-1:0] != next_index[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    mis1_r <= mis_nxt;
    if (mis_nxt) t1_r <= 13'd0;
    else if (factor > 13'(ONE)) t1_r <= 13'(ONE);
    else t1_r <= factor;
    for (int i = 0; i < 3; i++) begin
      cur1_r[i] <= cur[i];
      dif1_r[i] <= 17'(nxt[i]) - 17'(cur[i]);
      nrm1_r[i] <= nrm[i];
    end
  end

  // stage 2: scale difference and add
  logic               v2_r;
  logic               mis2_r;
  logic signed [16:0] pos2_r [3];
  logic signed [15:0] nrm2_r [3];
  logic signed [30:0] prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      prod[i] = 31'(dif1_r[i]) * $signed({1'b0, t1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    mis2_r <= mis1_r;
    for (int i = 0; i < 3; i++) begin
      pos2_r[i] <= 17'(cur1_r[i]) + 17'(prod[i] >>> FRAC_BITS);
      nrm2_r[i] <= nrm1_r[i];
    end
  end

  assign out_vld = v2_r;
  assign pos     = pos2_r;
  assign nrm_o   = nrm2_r;
  assign mis     = mis2_r;

endmodule

// ===== design/mvts_xform.sv =====
module mvts_xform
  import mvts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [16:0] pos [3],
  input  logic signed [15:0] nrm [3],
  input  logic               mis,
  input  cfg_t               cfg,
  output logic               out_vld,
  output logic signed [31:0] clip [4],
  output logic [12:0]        col [3],
  output logic               out_mis
);

  logic [63:0] rows [4];
  assign rows[0] = cfg.row0;
  assign rows[1] = cfg.row1;
  assign rows[2] = cfg.row2;
  assign rows[3] = cfg.row3;

  // stage 3: products
  logic               v3_r;
  logic               mis3_r;
  logic signed [32:0] mp3_r [4][4];
  logic signed [31:0] np3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    mis3_r <= mis;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++)
        mp3_r[i][j] <= $signed(rows[i][16*j +: 16]) * pos[j];
      mp3_r[i][3] <= 33'($signed(rows[i][48 +: 16])) <<< FRAC_BITS;
    end
    for (int k = 0; k < 3; k++)
      np3_r[k] <= nrm[k] * $signed(cfg.axis[16*k +: 16]);
  end

  // stage 4: sums
  logic               v4_r;
  logic               mis4_r;
  logic signed [31:0] clip4_r [4];
  logic signed [34:0] shade4_r;
  logic signed [35:0] acc [4];

  always_comb begin
    for (int i = 0; i < 4; i++)
      acc[i] = 36'(mp3_r[i][0]) + 36'(mp3_r[i][1]) + 36'(mp3_r[i][2])
             + 36'(mp3_r[i][3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    mis4_r <= mis3_r;
    for (int i = 0; i < 4; i++)
      clip4_r[i] <= sat32(48'(acc[i] >>> FRAC_BITS));
    shade4_r <= 35'(ONE * ONE) + 35'(np3_r[0]) + 35'(np3_r[1]) + 35'(np3_r[2]);
  end

  // stage 5: color scale and clamp, forced red on index mismatch
  logic               v5_r;
  logic               mis5_r;
  logic signed [31:0] clip5_r [4];
  logic [12:0]        col5_r [3];
  logic signed [51:0] cprod [3];
  logic signed [51:0] csh [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cprod[k] = 52'(shade4_r) * $signed({36'd0, cfg.color[16*k +: 16]});
      csh[k]   = cprod[k] >>> (2*FRAC_BITS + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    mis5_r  <= mis4_r;
    clip5_r <= clip4_r;
    for (int k = 0; k < 3; k++) begin
      if (mis4_r) col5_r[k] <= (k == 0) ? 13'(ONE) : 13'd0;
      else if (csh[k] < 0) col5_r[k] <= 13'd0;
      else if (csh[k] > 52'(ONE)) col5_r[k] <= 13'(ONE);
      else col5_r[k] <= csh[k][12:0];
    end
  end

  assign out_vld = v5_r;
  assign clip    = clip5_r;
  assign col     = col5_r;
  assign out_mis = mis5_r;

  // a forced-red result never carries green or blue
  assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && mis5_r |-> col5_r[1] == 13'd0 && col5_r[2] == 13'd0)
    else $error("mismatch color not pure red");
  // colors stay within one
  assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> col5_r[0] <= 13'(ONE) && col5_r[1] <= 13'(ONE) && col5_r[2] <= 13'(ONE))
    else $error("color above one");
  // valid travels down without loss
  assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ##2 v5_r)
    else $error("valid lost in pipe");

endmodule

// ===== bench/mvts_checker.sv =====
module mvts_checker
  import mvts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_start,
  input  logic               in_busy,
  input  logic signed [15:0] in_cur_x,
  input  logic signed [15:0] in_cur_y,
  input  logic signed [15:0] in_cur_z,
  input  logic signed [15:0] in_next_x,
  input  logic signed [15:0] in_next_y,
  input  logic signed [15:0] in_next_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [15:0]        in_cur_index,
  input  logic [15:0]        in_next_index,
  input  logic               out_strobe,
  input  logic signed [31:0] out_clip_x,
  input  logic signed [31:0] out_clip_y,
  input  logic signed [31:0] out_clip_z,
  input  logic signed [31:0] out_clip_w,
  input  logic [12:0]        out_red,
  input  logic [12:0]        out_green,
  input  logic [12:0]        out_blue,
  input  logic               out_pair_mismatch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [5:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0][15:0] coord;  // cur xyz, next xyz, normal xyz
    logic [15:0]      cur_idx;
    logic [15:0]      next_idx;
  } vertex_t;

  typedef struct packed {
    logic [3:0][31:0] clip;
    logic [12:0]      red;
    logic [12:0]      green;
    logic [12:0]      blue;
    logic             mism;
  } shaded_t;

  // shadow copy of the register file
  logic [12:0] factor;
  logic [47:0] axis;
  logic [47:0] color;
  logic [63:0] rows [4];

  shaded_t shaded_q[$];

  // transform and shade one vertex under the current register settings
  function automatic shaded_t shade_vertex(input vertex_t v);
    shaded_t r;
    longint t, acc, s, shade, ch;
    longint p [4];
    logic mism;
    mism = v.cur_idx[INDEX_BITS-1:0] != v.next_idx[INDEX_BITS-1:0];
    t = (factor > ONE) ? ONE : factor;
    if (mism) t = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(v.coord[i])) +
             (((longint'($signed(v.coord[3+i])) - longint'($signed(v.coord[i]))) * t)
              >>> FRAC_BITS);
    end
    p[3] = ONE;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++)
        acc += longint'($signed(rows[i][16*j +: 16])) * p[j];
      acc = acc >>> FRAC_BITS;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      r.clip[i] = acc[31:0];
    end
    s = 0;
    for (int i = 0; i < 3; i++)
      s += longint'($signed(v.coord[6+i])) * longint'($signed(axis[16*i +: 16]));
    shade = longint'(ONE) * ONE + s;
    for (int i = 0; i < 3; i++) begin
      ch = (shade * longint'(color[16*i +: 16])) >>> (2*FRAC_BITS + 1);
      if (ch < 0) ch = 0;
      if (ch > ONE) ch = ONE;
      if (i == 0) r.red = ch[12:0];
      else if (i == 1) r.green = ch[12:0];
      else r.blue = ch[12:0];
    end
    if (mism) begin
      r.red = 13'(ONE);
      r.green = '0;
      r.blue = '0;
    end
    r.mism = mism;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    vertex_t v;
    shaded_t e;
    if (!rst_n) begin
      factor = '0;
      axis = '0;
      color = '0;
      for (int i = 0; i < 4; i++) rows[i] = '0;
    end else begin
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[5:3])
          REG_FACTOR: factor = cfg_pwdata[12:0];
          REG_AXIS:   axis = cfg_pwdata[47:0];
          REG_COLOR:  color = cfg_pwdata[47:0];
          REG_ROW0:   rows[0] = cfg_pwdata;
          REG_ROW1:   rows[1] = cfg_pwdata;
          REG_ROW2:   rows[2] = cfg_pwdata;
          REG_ROW3:   rows[3] = cfg_pwdata;
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (out_strobe) begin
        if (shaded_q.size() == 0) begin
          $display("result with no vertex outstanding");
          fail_count++;
        end else begin
          e = shaded_q.pop_front();
          if (out_clip_x !== e.clip[0]) report("clip_x", out_clip_x, $signed(e.clip[0]));
          if (out_clip_y !== e.clip[1]) report("clip_y", out_clip_y, $signed(e.clip[1]));
          if (out_clip_z !== e.clip[2]) report("clip_z", out_clip_z, $signed(e.clip[2]));
          if (out_clip_w !== e.clip[3]) report("clip_w", out_clip_w, $signed(e.clip[3]));
          if (out_red !== e.red) report("red", out_red, e.red);
          if (out_green !== e.green) report("green", out_green, e.green);
          if (out_blue !== e.blue) report("blue", out_blue, e.blue);
          if (out_pair_mismatch !== e.mism)
            report("pair_mismatch", out_pair_mismatch, e.mism);
        end
      end
      // vertex transfer
      if (in_start && !in_busy) begin
        v.coord = {in_normal_z, in_normal_y, in_normal_x, in_next_z, in_next_y,
                   in_next_x, in_cur_z, in_cur_y, in_cur_x};
        v.cur_idx = in_cur_index;
        v.next_idx = in_next_index;
        shaded_q.push_back(shade_vertex(v));
      end
    end
    pending_count <= shaded_q.size();
  end

endmodule

// ===== bench/morph_vertex_transform_shade_tb.sv =====
module morph_vertex_transform_shade_tb
  import mvts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 160;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_start = 1'b0;
  logic               in_busy;
  logic signed [15:0] in_cur_x = '0, in_cur_y = '0, in_cur_z = '0;
  logic signed [15:0] in_next_x = '0, in_next_y = '0, in_next_z = '0;
  logic signed [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [15:0]        in_cur_index = '0, in_next_index = '0;
  logic               out_strobe;
  logic signed [31:0] out_clip_x, out_clip_y, out_clip_z, out_clip_w;
  logic [12:0]        out_red, out_green, out_blue;
  logic               out_pair_mismatch;
  logic               cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [5:0]         cfg_paddr = '0;
  logic [63:0]        cfg_pwdata = '0;
  logic [63:0]        cfg_prdata;
  logic               cfg_pready;
  int                 fail_count, pending_count;
  int                 idle_cycles = 0;
  bit                 gaps_on = 1'b0;

  always #5 clk = ~clk;

  morph_vertex_transform_shade DUT (.*);
  mvts_checker checker_i (.*);

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((in_start && !in_busy) || out_strobe || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] d);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic load_config(input logic [12:0] f, input logic [47:0] ax,
                             input logic [47:0] col, input logic [3:0][63:0] m);
    cfg_write(REG_FACTOR, {51'($urandom), f});
    cfg_write(REG_AXIS, {16'($urandom), ax});
    cfg_write(REG_COLOR, {16'($urandom), col});
    cfg_write(REG_ROW0, m[0]);
    cfg_write(REG_ROW1, m[1]);
    cfg_write(REG_ROW2, m[2]);
    cfg_write(REG_ROW3, m[3]);
  endtask

  // wait until every vertex has come back and the pipeline is empty
  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one vertex transfer; v holds cur xyz, next xyz, normal xyz, indices
  task automatic send_vertex(input logic [10:0][15:0] v);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cur_x <= v[0];    in_cur_y <= v[1];    in_cur_z <= v[2];
    in_next_x <= v[3];   in_next_y <= v[4];   in_next_z <= v[5];
    in_normal_x <= v[6]; in_normal_y <= v[7]; in_normal_z <= v[8];
    in_cur_index <= v[9];
    in_next_index <= v[10];
    in_start <= 1'b1;
    do @(posedge clk); while (in_busy);
  endtask

  task automatic random_vertex();
    logic [10:0][15:0] v;
    for (int i = 0; i < 9; i++) v[i] = ($urandom_range(0, 3) == 0) ? pick16() : 16'($urandom);
    v[9] = 16'($urandom);
    case ($urandom_range(0, 7))
      0: v[10] = 16'($urandom);
      1: v[10] = v[9] ^ (16'd1 << $urandom_range(0, 15));
      default: v[10] = v[9];
    endcase
    send_vertex(v);
  endtask

  initial begin
    logic [10:0][15:0] v;
    logic [3:0][63:0]  m;
    logic [12:0]       f;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, index match and miss, factor half / one / above one
    for (int c = 0; c < 3; c++) begin
      m[0] = 64'h0000_0000_0000_1000;
      m[1] = 64'h0000_0000_1000_0000;
      m[2] = (c == 1) ? 64'h7fff_7fff_7fff_7fff : 64'h0000_1000_0000_0000;
      m[3] = (c == 2) ? 64'h8000_8000_8000_8000 : 64'h1000_0000_0000_0000;
      f = (c == 0) ? 13'd2048 : (c == 1) ? 13'(ONE) : 13'h1fff;
      load_config(f, (c == 0) ? 48'h0000_0000_1000 : 48'h8000_7fff_8000,
                  (c == 2) ? 48'hffff_ffff_ffff : 48'h1000_0800_0400, m);
      if (c == 0) cfg_write(REG_NONE, 64'hdead_beef_dead_beef);
      for (int k = 0; k < 7; k++) begin
        for (int i = 0; i < 9; i++)
          v[i] = (k == 0) ? 16'h0000 : (k == 1) ? 16'h7fff : (k == 2) ? 16'h8000 :
                 (i < 3) ? 16'h8000 : 16'h7fff;
        v[9] = (k == 4) ? 16'hffff : 16'h0000;
        v[10] = (k == 5) ? 16'h8000 : (k == 6) ? 16'h0001 : v[9];
        send_vertex(v);
      end
      in_start <= 1'b0;
      drain();
    end

    // random phases, each with a fresh configuration; the drain is the full pause
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: f = '0;
        1: f = 13'(ONE);
        2: f = 13'h1fff;
        default: f = 13'($urandom_range(0, 8191));
      endcase
      for (int i = 0; i < 4; i++)
        m[i] = (ph == 5) ? {4{16'h7fff}} : (ph == 6) ? {4{16'h8000}} :
               {pick16(), pick16(), pick16(), pick16()};
      load_config(f, {pick16(), pick16(), pick16()}, {pick16(), pick16(), pick16()}, m);
      gaps_on = (ph % 3 != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) gaps_on = !gaps_on;
        random_vertex();
      end
      in_start <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== morph_vertex_transform_shade.f =====
design/mvts_pkg.sv
design/mvts_regs.sv
design/mvts_blend.sv
design/mvts_xform.sv
design/morph_vertex_transform_shade.sv
bench/mvts_checker.sv
bench/morph_vertex_transform_shade_tb.sv
